### design/per_port_latency_stats_top_defines.svh
// assertion macros for the per-port latency statistics checker
// used by ppls_checker.sv only; expects i_clk and i_rst_n in scope
`ifndef PER_PORT_LATENCY_STATS_TOP_DEFINES_SVH
`define PER_PORT_LATENCY_STATS_TOP_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define PPLS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define PPLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ppls_pkg.sv
// shared types and constants for the per-port latency statistics block
// no dependencies
package ppls_pkg;

    localparam int PORT_W = 11;
    localparam int TIME_W = 48;
    localparam int LAT_W  = 64;
    localparam int STAT_W = 4 * LAT_W;

    typedef enum logic {
        CMD_RECORD = 1'b0,
        CMD_READ   = 1'b1
    } t_cmd;

    // first member sits in the top bits, so max lands in the lowest bits
    typedef struct packed {
        logic [LAT_W-1:0] lat_sum;
        logic [LAT_W-1:0] sample_count;
        logic [LAT_W-1:0] lat_min;
        logic [LAT_W-1:0] lat_max;
    } t_stats;

endpackage

### design/ppls_front.sv
// front end: accepts requests, maps the port to a bucket, works out latency
// depends on ppls_pkg
module ppls_front
    import ppls_pkg::*;
#(
    parameter int PORTS = 1024,
    parameter int AW    = 11,
    parameter int QW    = 1 + AW + LAT_W
) (
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_cmd,
    input  logic [PORT_W-1:0] i_port,
    input  logic [TIME_W-1:0] i_current_time,
    input  logic [LAT_W-1:0]  i_prior_time,
    input  logic              i_clearing,
    input  logic              i_q_ready,
    output logic              o_q_valid,
    output logic [QW-1:0]     o_q_data
);

    logic [PORT_W:0]  port_ext;
    logic [AW-1:0]    bucket;
    logic [LAT_W-1:0] latency;

    assign port_ext = {1'b0, i_port};

    // anything at or above PORTS goes to the reserved bucket
    always_comb begin
        if (port_ext >= (PORT_W+1)'(PORTS)) begin
            bucket = AW'(PORTS);
        end else begin
            bucket = AW'(port_ext);
        end
    end

    assign latency = {{(LAT_W-TIME_W){1'b0}}, i_current_time} - i_prior_time;

    assign o_ready   = i_q_ready && !i_clearing;
    assign o_q_valid = i_valid && !i_clearing;
    assign o_q_data  = {latency, bucket, i_cmd};

endmodule

### design/ppls_queue.sv
// two-entry queue between the front end and the table engine
// no dependencies
module ppls_queue #(
    parameter int W = 76
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wptr;
    logic         r_rptr;
    logic [1:0]   r_count;
    logic         push;
    logic         pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            unique case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

### design/ppls_back.sv
// table engine: statistics memory, read-modify-write, clearing pass, result register
// depends on ppls_pkg
module ppls_back
    import ppls_pkg::*;
#(
    parameter int ENTRIES = 1025,
    parameter int AW      = 11,
    parameter int QW      = 1 + AW + LAT_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    output logic              o_q_ready,
    input  logic [QW-1:0]     i_q_data,
    output logic              o_clearing,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [STAT_W-1:0] o_data
);

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_UPDATE
    } t_state;

    t_state           r_state;
    logic [AW-1:0]    r_clr_addr;
    logic [AW-1:0]    r_addr;
    t_cmd             r_cmd;
    logic [LAT_W-1:0] r_lat;
    logic             r_out_valid;
    t_stats           r_out_data;
    t_stats           r_rd_data;
    t_stats           r_mem [ENTRIES];

    logic             pop;
    logic             can_out;
    logic             n_out_valid;
    logic             we;
    logic [AW-1:0]    wa;
    t_stats           wd;
    t_stats           upd;
    logic [AW-1:0]    q_bucket;

    assign q_bucket    = i_q_data[AW:1];
    assign pop         = (r_state == B_IDLE) && i_q_valid;
    assign o_q_ready   = (r_state == B_IDLE);
    assign o_clearing  = (r_state == B_CLEAR);
    assign can_out     = !r_out_valid || i_ready;
    assign n_out_valid = ((r_state == B_UPDATE) && can_out) || (r_out_valid && !i_ready);
    assign o_valid     = r_out_valid;
    assign o_data      = r_out_data;

    // max, min, count and total are independent of each other
    always_comb begin
        upd = r_rd_data;
        if (r_cmd == CMD_RECORD) begin
            if (r_lat > r_rd_data.lat_max) begin
                upd.lat_max = r_lat;
            end
            // a stored minimum of zero means no sample yet
            if (r_lat < r_rd_data.lat_min || r_rd_data.lat_min == '0) begin
                upd.lat_min = r_lat;
            end
            upd.sample_count = r_rd_data.sample_count + LAT_W'(1);
            upd.lat_sum      = r_rd_data.lat_sum + r_lat;
        end
    end

    always_comb begin
        we = 1'b0;
        wa = r_addr;
        wd = upd;
        unique case (r_state)
            B_CLEAR: begin
                we = 1'b1;
                wa = r_clr_addr;
                wd = '0;
            end
            B_UPDATE: begin
                we = can_out && (r_cmd == CMD_RECORD);
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (pop) begin
            r_rd_data <= r_mem[q_bucket];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            unique case (r_state)
                B_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(ENTRIES - 1)) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (pop) begin
                        r_cmd   <= t_cmd'(i_q_data[0]);
                        r_addr  <= q_bucket;
                        r_lat   <= i_q_data[QW-1:AW+1];
                        r_state <= B_UPDATE;
                    end
                end
                B_UPDATE: begin
                    if (can_out) begin
                        r_out_data <= upd;
                        r_state    <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

### design/per_port_latency_stats_top.sv
// per-port latency statistics, top level
// depends on ppls_pkg, ppls_front, ppls_queue, ppls_back
//
// Slave stream carries requests: tuser is the command (record a sample or read),
// tdata holds port, arrival time and prior time. Master stream returns one result
// per request: the addressed entry after the step (max, min, count, total).
// Ports at or above PORTS share one reserved bucket at index PORTS.
// An accepted request passes through the queue, the entry read and the update
// step before its result sets tvalid from the output register.
// The statistics table is a single RAM: each request reads its entry in B_IDLE,
// a record writes it back in B_UPDATE, and no new request leaves the queue until then.
// Up to two further requests wait in the queue between front end and table engine.
// Reset: synchronous, active low. Afterwards every table entry, the reserved
// bucket included, is swept to zero, during which s_axis_tready stays low.
// A stalled master side holds the result in the output register; the engine
// waits with its next update, and the queue fills before s_axis_tready drops.
module per_port_latency_stats_top
    import ppls_pkg::*;
#(
    parameter int PORTS = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,  // port[10:0], current_time[58:11], prior_time[122:59]
    input  logic          s_axis_tuser,  // cmd
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [255:0]  m_axis_tdata   // max[63:0], min[127:64], count[191:128], total[255:192]
);

    localparam int ENTRIES = PORTS + 1;
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int QW      = 1 + AW + LAT_W;

    logic          q_in_valid;
    logic          q_in_ready;
    logic [QW-1:0] q_in_data;
    logic          q_out_valid;
    logic          q_out_ready;
    logic [QW-1:0] q_out_data;
    logic          clearing;

    ppls_front #(
        .PORTS (PORTS),
        .AW    (AW),
        .QW    (QW)
    ) u_front (
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_cmd          (s_axis_tuser),
        .i_port         (s_axis_tdata[PORT_W-1:0]),
        .i_current_time (s_axis_tdata[PORT_W +: TIME_W]),
        .i_prior_time   (s_axis_tdata[PORT_W+TIME_W +: LAT_W]),
        .i_clearing     (clearing),
        .i_q_ready      (q_in_ready),
        .o_q_valid      (q_in_valid),
        .o_q_data       (q_in_data)
    );

    ppls_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_in_valid),
        .o_ready (q_in_ready),
        .i_data  (q_in_data),
        .o_valid (q_out_valid),
        .i_ready (q_out_ready),
        .o_data  (q_out_data)
    );

    ppls_back #(
        .ENTRIES (ENTRIES),
        .AW      (AW),
        .QW      (QW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_out_valid),
        .o_q_ready  (q_out_ready),
        .i_q_data   (q_out_data),
        .o_clearing (clearing),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata)
    );

endmodule

### design/ppls_checker.sv
// port-level checks for the per-port latency statistics block, bound to the top
// depends on per_port_latency_stats_top_defines.svh
`include "per_port_latency_stats_top_defines.svh"

module ppls_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [127:0] s_axis_tdata,
    input logic         s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [255:0] m_axis_tdata
);

    // result held until the receiver takes it
    `PPLS_ASSERT_NEXT(a_result_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

    // table sweep runs straight after reset, no request taken
    `PPLS_ASSERT_NOW(a_sweep_blocks, $rose(i_rst_n), !s_axis_tready, "request taken during table sweep")

    // nothing comes out before any request could have gone in
    `PPLS_ASSERT_NOW(a_no_early_result, $rose(i_rst_n), !m_axis_tvalid, "result shown straight after reset")

    // once an entry holds samples its minimum never exceeds its maximum
    `PPLS_ASSERT_NOW(a_min_le_max, m_axis_tvalid && m_axis_tdata[191:128] != 64'd0, m_axis_tdata[127:64] <= m_axis_tdata[63:0], "minimum above maximum")

endmodule

bind per_port_latency_stats_top ppls_checker u_checker (.*);

### sim/ppls_stats_monitor.sv
// stream monitor and scoreboard for the per-port latency statistics block
// keeps its own copy of the statistics table; depends on ppls_pkg
module ppls_stats_monitor
    import ppls_pkg::*;
#(
    parameter int PORTS = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // port[10:0], current_time[58:11], prior_time[122:59]
    input  logic         s_axis_tuser,  // cmd
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [255:0] m_axis_tdata,  // max[63:0], min[127:64], count[191:128], total[255:192]
    output int           o_errors,
    output int           o_pending,
    output int           o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [LAT_W-1:0] peak_tab  [0:PORTS];
    logic [LAT_W-1:0] floor_tab [0:PORTS];
    logic [LAT_W-1:0] count_tab [0:PORTS];
    logic [LAT_W-1:0] sum_tab   [0:PORTS];

    t_stats entry_after_q [$];
    int     errors  = 0;
    int     checked = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
    end

    // apply one request to the shadow table and return the entry it leaves
    function automatic t_stats update_entry(t_cmd cmd, logic [PORT_W-1:0] port,
                                            logic [TIME_W-1:0] arrival,
                                            logic [LAT_W-1:0] prior);
        int               bucket;
        logic [LAT_W-1:0] lat;
        t_stats           entry;
        bucket = (port >= PORTS) ? PORTS : int'(port);
        if (cmd == CMD_RECORD) begin
            lat = {{(LAT_W-TIME_W){1'b0}}, arrival} - prior;
            if (lat > peak_tab[bucket])
                peak_tab[bucket] = lat;
            // a stored zero counts as empty
            if (lat < floor_tab[bucket] || floor_tab[bucket] == '0)
                floor_tab[bucket] = lat;
            count_tab[bucket] = count_tab[bucket] + LAT_W'(1);
            sum_tab[bucket]   = sum_tab[bucket] + lat;
        end
        entry.lat_max      = peak_tab[bucket];
        entry.lat_min      = floor_tab[bucket];
        entry.sample_count = count_tab[bucket];
        entry.lat_sum      = sum_tab[bucket];
        return entry;
    endfunction

    task automatic compare_field(string name, logic [LAT_W-1:0] want, logic [LAT_W-1:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= 10)
                $display("result %0d, %s: expected %h, got %h", checked, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_stats got;
        t_stats want;
        if (!i_rst_n) begin
            for (int i = 0; i <= PORTS; i++) begin
                peak_tab[i]  = '0;
                floor_tab[i] = '0;
                count_tab[i] = '0;
                sum_tab[i]   = '0;
            end
            entry_after_q.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                entry_after_q.push_back(update_entry(t_cmd'(s_axis_tuser),
                    s_axis_tdata[10:0], s_axis_tdata[58:11], s_axis_tdata[122:59]));
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_stats'(m_axis_tdata);
                if (entry_after_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result %h", m_axis_tdata);
                end else begin
                    want = entry_after_q.pop_front();
                    compare_field("lat_max", want.lat_max, got.lat_max);
                    compare_field("lat_min", want.lat_min, got.lat_min);
                    compare_field("sample_count", want.sample_count, got.sample_count);
                    compare_field("lat_sum", want.lat_sum, got.lat_sum);
                    checked++;
                end
            end
        end
        o_errors  <= errors;
        o_pending <= entry_after_q.size();
        o_checked <= checked;
    end

endmodule

### sim/tb_per_port_latency_stats_top.sv
// top-level testbench for per_port_latency_stats_top: clock, reset, request traffic
// and output back-pressure; checking lives in ppls_stats_monitor, types in ppls_pkg
module tb_per_port_latency_stats_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ppls_pkg::*;

    localparam int PORTS       = 1024;
    localparam int N_RANDOM    = 1525;
    localparam int N_PHASES    = 5;
    localparam int HOLD_CYCLES = 300;
    localparam int LIMIT       = 400000;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata  = '0;  // port[10:0], current_time[58:11], prior_time[122:59]
    logic         s_axis_tuser  = 1'b0; // cmd
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [255:0] m_axis_tdata;        // max[63:0], min[127:64], count[191:128], total[255:192]

    int chk_errors;
    int chk_pending;
    int chk_checked;

    int cycles     = 0;
    int idle_pct   = 0;
    int stall_pct  = 0;
    int hold_token = 0;
    int hold_taken = 0;
    int hold_left  = 0;
    int n_sent     = 0;
    int n_reads    = 0;

    per_port_latency_stats_top #(.PORTS(PORTS)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ppls_stats_monitor #(.PORTS(PORTS)) monitor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_errors      (chk_errors),
        .o_pending     (chk_pending),
        .o_checked     (chk_checked)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycles, chk_pending);
            $display("tb_per_port_latency_stats_top: done, errors");
            $finish;
        end
    end

    // result side: random stalls, or a long hold-off when one is asked for
    always @(posedge i_clk) begin
        if (hold_token != hold_taken) begin
            hold_taken    <= hold_token;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_req(t_cmd cmd, logic [PORT_W-1:0] port,
                            logic [TIME_W-1:0] arrival, logic [LAT_W-1:0] prior);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {5'b0, prior, arrival, port};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        n_sent++;
        if (cmd == CMD_READ)
            n_reads++;
    endtask

    task automatic send_random_req();
        t_cmd              cmd;
        logic [PORT_W-1:0] port;
        logic [63:0]       r;
        logic [TIME_W-1:0] arrival;
        logic [LAT_W-1:0]  prior;
        cmd = ($urandom_range(3) == 0) ? CMD_READ : CMD_RECORD;
        // keep a few entries busy so their statistics build up
        case ($urandom_range(3))
            0:       port = PORT_W'($urandom_range(7));
            1:       port = PORT_W'($urandom_range(2047, 1020));
            default: port = PORT_W'($urandom_range(2047));
        endcase
        r       = {$urandom, $urandom};
        arrival = r[TIME_W-1:0];
        case ($urandom_range(9))
            0:       prior = {16'h0, arrival};
            1:       prior = {$urandom, $urandom};
            2:       prior = {16'h0, arrival} + $urandom_range(100000);
            default: prior = {16'h0, arrival} - $urandom_range(100000);
        endcase
        send_req(cmd, port, arrival, prior);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        stall_pct <= 20;
        idle_pct   = 20;
        // min/max tracking, zero latency as empty, then replaced
        send_req(CMD_READ,   11'd0, 48'd0,    64'd0);
        send_req(CMD_RECORD, 11'd0, 48'd1000, 64'd400);
        send_req(CMD_RECORD, 11'd0, 48'd5000, 64'd1000);
        send_req(CMD_RECORD, 11'd0, 48'd300,  64'd290);
        send_req(CMD_RECORD, 11'd0, 48'd777,  64'd777);
        send_req(CMD_RECORD, 11'd0, 48'd60,   64'd10);
        send_req(CMD_READ,   11'd0, '1,       '1);
        // timestamp extremes and wrapping differences
        send_req(CMD_RECORD, 11'd1, '1,       64'd0);
        send_req(CMD_RECORD, 11'd1, 48'd0,    '1);
        send_req(CMD_RECORD, 11'd2, 48'd10,   64'd20);
        send_req(CMD_RECORD, 11'd2, 48'd0,    64'h8000_0000_0000_0000);
        send_req(CMD_RECORD, 11'd2, 48'd0,    64'd1);
        send_req(CMD_RECORD, 11'd1023, '1,    '1);
        // out-of-range ports all land in the reserved bucket
        send_req(CMD_RECORD, 11'd1024, 48'd100, 64'd1);
        send_req(CMD_RECORD, 11'd1500, 48'd100, 64'd50);
        send_req(CMD_RECORD, 11'd2047, 48'd100, 64'd99);
        send_req(CMD_READ,   11'd2047, 48'd0,   64'd0);
        send_req(CMD_READ,   11'd1024, '1,      '1);
        send_req(CMD_READ,   11'd1023, 48'd0,   64'd0);
        send_req(CMD_READ,   11'd2,    48'd0,   64'd0);
        send_req(CMD_READ,   11'd1,    48'd0,   64'd0);
        send_req(CMD_RECORD, 11'h555, 48'hAAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_req(CMD_RECORD, 11'h2AA, 48'h5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);

        for (int phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 79; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 79; end
                3: begin idle_pct = 38; stall_pct <= 38; end
                default: begin
                    // output held off while requests keep coming, input must back up
                    idle_pct = 0;
                    stall_pct <= 0;
                    hold_token <= hold_token + 1;
                end
            endcase
            repeat (N_RANDOM / N_PHASES) send_random_req();
        end
        s_axis_tvalid <= 1'b0;

        do
            @(posedge i_clk);
        while (chk_pending != 0);
        repeat (8) @(posedge i_clk);

        $display("%0d requests sent (%0d reads), %0d results compared in %0d cycles",
                 n_sent, n_reads, chk_checked, cycles);
        $display("traffic: free-running, sender idle, receiver stalled, both, %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (chk_errors == 0 && chk_pending == 0)
            $display("tb_per_port_latency_stats_top: done, clean");
        else
            $display("tb_per_port_latency_stats_top: done, errors");
        $finish;
    end

endmodule
